>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and gated by the active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/lrj_pkg.sv
// ----------------------------------------------------------------------------
// lrj_pkg
// types and constants of the longest-remaining-job scheduler
// ----------------------------------------------------------------------------
package lrj_pkg;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned SLOT_W    = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADMIT = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_ADMITTED = 3'd0,
    STS_REJECTED = 3'd1,
    STS_RAN      = 3'd2,
    STS_IDLE     = 3'd3,
    STS_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  proc_id;
    logic [15:0] burst;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  ran_slot;
    logic [7:0]  ran_id;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } out_word_t;

  // one process table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic        done;
  } entry_t;

  // table access request from the sequencer
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } tbl_req_t;

endpackage

>>> src/longest_remaining_job_scheduler.sv
// ----------------------------------------------------------------------------
// longest_remaining_job_scheduler
// preemptive longest-remaining-job-first scheduler with a unit time quantum
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o / in_word_i) takes one command word:
//   tick, admit or clear. output channel (out_valid_o / out_stall_i /
//   out_word_o) returns exactly one result word per command, in order.
//   flow: admit, clear, reject and an idle tick on an empty table go from
//   idle straight to the done state, which hands the result to the output
//   register. a tick on a non-empty table passes through scan and update
//   first: the process table is a single-read-port memory, so the
//   largest-remaining search reads one slot per cycle, then the update
//   state writes back the chosen slot. the block works on one command at a
//   time, so it takes no new command until the result of the last one has
//   been handed to the output register.
//   the output register holds a finished word while the receiver stalls;
//   the next command can be accepted meanwhile, and its result waits
//   internally, with the input stalled, until the output register frees up.
//   reset: time and slot count go to zero, no word is pending. the table
//   memory is not cleared, only slots below the slot count are ever compared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_remaining_job_scheduler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrj_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lrj_pkg::out_word_t out_word_o
);

  localparam int unsigned SlotW = lrj_pkg::SLOT_W;
  localparam int unsigned CntW  = lrj_pkg::CNT_W;

  // control state
  lrj_pkg::state_e   state_q, state_d;
  logic [31:0]       now_q, now_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [SlotW-1:0]  scan_q, scan_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic [SlotW-1:0]  best_slot_q, best_slot_d;
  lrj_pkg::entry_t   best_q, best_d;
  lrj_pkg::out_word_t res_q, res_d;
  lrj_pkg::out_word_t out_q, out_d;

  // table interface
  lrj_pkg::tbl_req_t tbl_req;
  lrj_pkg::entry_t   rdata;
  logic [15:0]       rem_new;
  logic              scan_last;

  lrj_table u_table (
    .clk_i     (clk_i),
    .tbl_req_i (tbl_req),
    .rdata_o   (rdata)
  );

  assign in_stall_o  = (state_q != lrj_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // remaining burst of the chosen slot after this tick
  assign rem_new   = best_q.remaining - 16'd1;
  // data for the last used slot is on the read port
  assign scan_last = ((CntW'(scan_q) + CntW'(1)) == used_q);

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    used_d      = used_q;
    scan_d      = scan_q;
    found_d     = found_q;
    best_slot_d = best_slot_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    tbl_req       = '0;
    tbl_req.waddr = used_q[SlotW-1:0];
    // prefetch the slot after the one being compared
    tbl_req.raddr = scan_q + SlotW'(1);

    // receiver takes the pending word
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lrj_pkg::ST_IDLE: begin
        tbl_req.raddr = '0;
        if (in_valid_i) begin
          res_d        = '0;
          res_d.status = lrj_pkg::STS_REJECTED;
          state_d      = lrj_pkg::ST_DONE;
          unique case (in_word_i.command)
            lrj_pkg::CMD_TICK: begin
              now_d   = now_q + 32'd1;
              found_d = 1'b0;
              scan_d  = '0;
              if (used_q == '0) begin
                res_d.status = lrj_pkg::STS_IDLE;
              end else begin
                state_d = lrj_pkg::ST_SCAN;
              end
            end
            lrj_pkg::CMD_ADMIT: begin
              if (in_word_i.burst != 16'd0 && used_q < CntW'(lrj_pkg::MAX_PROCS)) begin
                tbl_req.we                = 1'b1;
                tbl_req.wdata.id          = in_word_i.proc_id;
                tbl_req.wdata.arrival     = now_q;
                tbl_req.wdata.burst       = in_word_i.burst;
                tbl_req.wdata.remaining   = in_word_i.burst;
                tbl_req.wdata.done        = 1'b0;
                used_d                    = used_q + CntW'(1);
                res_d.status              = lrj_pkg::STS_ADMITTED;
                res_d.ran_slot            = 4'(used_q[SlotW-1:0]);
                res_d.ran_id              = in_word_i.proc_id;
              end
            end
            lrj_pkg::CMD_CLEAR: begin
              used_d       = '0;
              now_d        = '0;
              res_d.status = lrj_pkg::STS_CLEARED;
            end
            lrj_pkg::CMD_RSVD: begin
              res_d.status = lrj_pkg::STS_REJECTED;
            end
            default: begin
              res_d.status = lrj_pkg::STS_REJECTED;
            end
          endcase
        end
      end

      lrj_pkg::ST_SCAN: begin
        // strict greater keeps the lowest slot on a tie
        if (!rdata.done && (!found_q || rdata.remaining > best_q.remaining)) begin
          found_d     = 1'b1;
          best_slot_d = scan_q;
          best_d      = rdata;
        end
        if (scan_last) begin
          state_d = lrj_pkg::ST_UPDATE;
        end else begin
          scan_d = scan_q + SlotW'(1);
        end
      end

      lrj_pkg::ST_UPDATE: begin
        state_d = lrj_pkg::ST_DONE;
        if (!found_q) begin
          res_d.status = lrj_pkg::STS_IDLE;
        end else begin
          // write back the run slot
          tbl_req.we              = 1'b1;
          tbl_req.waddr           = best_slot_q;
          tbl_req.wdata           = best_q;
          tbl_req.wdata.remaining = rem_new;
          tbl_req.wdata.done      = (rem_new == 16'd0);
          res_d.status            = lrj_pkg::STS_RAN;
          res_d.ran_slot          = 4'(best_slot_q);
          res_d.ran_id            = best_q.id;
          if (rem_new == 16'd0) begin
            res_d.finished        = 1'b1;
            res_d.completion_time = now_q;
            res_d.turnaround      = now_q - best_q.arrival;
          end
        end
      end

      lrj_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d         = res_q;
          out_d.waiting = res_q.finished ? (res_q.turnaround - 32'(best_q.burst)) : '0;
          out_valid_d   = 1'b1;
          state_d       = lrj_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lrj_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrj_pkg::ST_IDLE;
      now_q       <= '0;
      used_q      <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      used_q      <= used_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_slot_q <= best_slot_d;
    best_q      <= best_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  // slot count never runs past the table
  `ASSERT_NEVER(a_used_in_range, used_q > CntW'(lrj_pkg::MAX_PROCS), "slot count overflow")
  // the scan only visits used slots
  `ASSERT_PROP(a_scan_in_range,
               state_q == lrj_pkg::ST_SCAN |-> CntW'(scan_q) < used_q,
               "scan past used slots")
  // the table is written only on admit or on the write-back of a tick
  `ASSERT_PROP(a_write_phase,
               tbl_req.we |-> (state_q == lrj_pkg::ST_IDLE || state_q == lrj_pkg::ST_UPDATE),
               "table write outside admit or update")
  // every accepted command leads to a pending result
  `ASSERT_PROP(a_accept_busy,
               in_valid_i && !in_stall_o |=> state_q != lrj_pkg::ST_IDLE,
               "accepted command dropped")

endmodule

>>> src/lrj_table.sv
// ----------------------------------------------------------------------------
// lrj_table
// process table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lrj_table (
  input  logic              clk_i,
  input  lrj_pkg::tbl_req_t tbl_req_i,
  output lrj_pkg::entry_t   rdata_o
);

  lrj_pkg::entry_t mem_q [lrj_pkg::MAX_PROCS];
  lrj_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (tbl_req_i.we) begin
      mem_q[tbl_req_i.waddr] <= tbl_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[tbl_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for longest_remaining_job_scheduler: a directed table
// of commands, then random admit/tick batches, with every result word checked
// against a software copy of the scheduler, random gaps on both channels and
// one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RANDOM_WORDS = 360;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AT      = 100;  // result count that starts the hold-off
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SLOT_W       = lrj_pkg::SLOT_W;

  // bursts of slots 1..15 in the directed fill; slots 3 and 7 tie for the top
  localparam logic [15:0] FILL_BURST [15] = '{16'd3, 16'd1, 16'd9, 16'd2, 16'd5,
                                              16'd7, 16'd9, 16'd4, 16'd1, 16'd6,
                                              16'd8, 16'd2, 16'd3, 16'd5, 16'd1};

  typedef struct {
    lrj_pkg::in_word_t  word;
    bit                 typed;  // want holds a hand-written result
    lrj_pkg::out_word_t want;
  } dir_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  lrj_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lrj_pkg::out_word_t out_word;

  // software copy of the scheduler state
  logic [31:0]  sim_now;
  int unsigned  ent_count;
  logic [7:0]   ent_id      [lrj_pkg::MAX_PROCS];
  logic [31:0]  ent_arrival [lrj_pkg::MAX_PROCS];
  logic [15:0]  ent_burst   [lrj_pkg::MAX_PROCS];
  logic [15:0]  ent_left    [lrj_pkg::MAX_PROCS];
  logic         ent_done    [lrj_pkg::MAX_PROCS];

  lrj_pkg::out_word_t sched_results_q [$];  // result words owed by the block, oldest first
  dir_row_t    dir_rows [$];
  int unsigned words_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned fail_count  = 0;
  int unsigned cycles      = 0;
  bit          no_gaps     = 1'b0;  // both sides run back to back while set

  longest_remaining_job_scheduler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic lrj_pkg::in_word_t mk_word(lrj_pkg::cmd_e c, logic [7:0] id,
                                                logic [15:0] b);
    lrj_pkg::in_word_t w;
    w.command = c;
    w.proc_id = id;
    w.burst   = b;
    return w;
  endfunction

  function automatic lrj_pkg::out_word_t word_out(lrj_pkg::status_e s, logic [3:0] slot,
                                                  logic [7:0] id, logic fin,
                                                  logic [31:0] ct, logic [31:0] tat,
                                                  logic [31:0] wt);
    lrj_pkg::out_word_t r;
    r.status          = s;
    r.ran_slot        = slot;
    r.ran_id          = id;
    r.finished        = fin;
    r.completion_time = ct;
    r.turnaround      = tat;
    r.waiting         = wt;
    return r;
  endfunction

  // one scheduler command: updates the software state, returns its result word
  function automatic lrj_pkg::out_word_t schedule_step(lrj_pkg::in_word_t w);
    lrj_pkg::out_word_t r;
    logic [SLOT_W-1:0]  pick;
    logic [SLOT_W-1:0]  slot;
    bit                 found;
    logic [31:0]        tat;
    r     = '0;
    pick  = '0;
    slot  = '0;
    found = 1'b0;
    case (w.command)
      lrj_pkg::CMD_ADMIT: begin
        if (w.burst == 16'd0 || ent_count >= lrj_pkg::MAX_PROCS) begin
          r.status = lrj_pkg::STS_REJECTED;
        end else begin
          slot              = SLOT_W'(ent_count);
          ent_id[slot]      = w.proc_id;
          ent_arrival[slot] = sim_now;
          ent_burst[slot]   = w.burst;
          ent_left[slot]    = w.burst;
          ent_done[slot]    = 1'b0;
          r.status   = lrj_pkg::STS_ADMITTED;
          r.ran_slot = 4'(slot);
          r.ran_id   = w.proc_id;
          ent_count++;
        end
      end
      lrj_pkg::CMD_CLEAR: begin
        ent_count = 0;
        sim_now   = '0;
        r.status  = lrj_pkg::STS_CLEARED;
      end
      lrj_pkg::CMD_TICK: begin
        // largest remaining wins, strict compare keeps the lowest slot on a tie
        for (int unsigned i = 0; i < ent_count; i++) begin
          if (!ent_done[SLOT_W'(i)] &&
              (!found || ent_left[SLOT_W'(i)] > ent_left[pick])) begin
            pick  = SLOT_W'(i);
            found = 1'b1;
          end
        end
        sim_now = sim_now + 32'd1;
        if (!found) begin
          r.status = lrj_pkg::STS_IDLE;
        end else begin
          if (ent_left[pick] != 16'd0) ent_left[pick] = ent_left[pick] - 16'd1;
          r.status   = lrj_pkg::STS_RAN;
          r.ran_slot = 4'(pick);
          r.ran_id   = ent_id[pick];
          if (ent_left[pick] == 16'd0) begin
            tat              = sim_now - ent_arrival[pick];
            ent_done[pick]   = 1'b1;
            r.finished        = 1'b1;
            r.completion_time = sim_now;
            r.turnaround      = tat;
            r.waiting         = tat - 32'(ent_burst[pick]);
          end
        end
      end
      default: r.status = lrj_pkg::STS_REJECTED;
    endcase
    return r;
  endfunction

  // offer one word after a random gap, hold it until taken, then log its result
  task automatic send_word(lrj_pkg::in_word_t w, bit typed, lrj_pkg::out_word_t want);
    int unsigned        gap;
    lrj_pkg::out_word_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = schedule_step(w);
    sched_results_q.push_back(typed ? want : r);
    words_sent++;
  endtask

  task automatic add_row(lrj_pkg::cmd_e c, logic [7:0] id, logic [15:0] b, bit typed,
                         lrj_pkg::out_word_t want);
    dir_row_t row;
    row.word  = mk_word(c, id, b);
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic check_result(lrj_pkg::out_word_t got);
    lrj_pkg::out_word_t want;
    if (sched_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result word: status %0d slot %0d id %0d", got.status,
                 got.ran_slot, got.ran_id);
      return;
    end
    want = sched_results_q.pop_front();
    if (got.status !== want.status || got.ran_slot !== want.ran_slot ||
        got.ran_id !== want.ran_id || got.finished !== want.finished ||
        got.completion_time !== want.completion_time ||
        got.turnaround !== want.turnaround || got.waiting !== want.waiting) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("result %0d mismatch, expected: sts %0d slot %0d id %0d fin %0d",
                 words_taken, want.status, want.ran_slot, want.ran_id, want.finished,
                 "  ct %0d tat %0d wt %0d",
                 want.completion_time, want.turnaround, want.waiting);
        $display("result %0d mismatch, actual:   sts %0d slot %0d id %0d fin %0d",
                 words_taken, got.status, got.ran_slot, got.ran_id, got.finished,
                 "  ct %0d tat %0d wt %0d",
                 got.completion_time, got.turnaround, got.waiting);
      end
    end
  endtask

  // receiver: random stall before each word, one long hold-off to back the block up
  initial begin : drain
    int unsigned hold;
    forever begin
      if (words_taken == HOLD_AT) hold = LONG_HOLD;
      else hold = no_gaps ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      check_result(out_word);
      words_taken++;
    end
  end

  initial begin : stimulus
    lrj_pkg::out_word_t none;
    int unsigned        base;
    int unsigned        n;
    int unsigned        tsum;
    int unsigned        ticks;
    int unsigned        pick;
    logic [15:0]        b;
    none      = '0;
    sim_now   = '0;
    ent_count = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty-table tick, reserved code, zero burst, field extremes,
    // clear, a one-unit job, a full table with a tie, a full-table reject, two ticks
    add_row(lrj_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b1,
            word_out(lrj_pkg::STS_IDLE, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_RSVD,  8'hFF, 16'hFFFF, 1'b1,
            word_out(lrj_pkg::STS_REJECTED, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_ADMIT, 8'h5A, 16'h0000, 1'b1,
            word_out(lrj_pkg::STS_REJECTED, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_ADMIT, 8'hFF, 16'hFFFF, 1'b1,
            word_out(lrj_pkg::STS_ADMITTED, 4'd0, 8'hFF, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_TICK,  8'hFF, 16'hFFFF, 1'b1,
            word_out(lrj_pkg::STS_RAN, 4'd0, 8'hFF, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF, 1'b1,
            word_out(lrj_pkg::STS_CLEARED, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_ADMIT, 8'h00, 16'h0001, 1'b1,
            word_out(lrj_pkg::STS_ADMITTED, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b1,
            word_out(lrj_pkg::STS_RAN, 4'd0, 8'h00, 1'b1, 1, 1, 0));
    add_row(lrj_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b1,
            word_out(lrj_pkg::STS_IDLE, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    for (int k = 0; k < 15; k++)
      add_row(lrj_pkg::CMD_ADMIT, 8'(8'h11 + k), FILL_BURST[4'(k)], 1'b0, none);
    add_row(lrj_pkg::CMD_ADMIT, 8'hEE, 16'h8000, 1'b1,
            word_out(lrj_pkg::STS_REJECTED, 4'd0, 8'h00, 1'b0, 0, 0, 0));
    add_row(lrj_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, none);
    add_row(lrj_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, none);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    // random batches: mostly clear, fill, run to completion, with noise mixed in
    base = words_sent;
    while (words_sent < base + RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0)
        send_word(mk_word(lrj_pkg::CMD_CLEAR, 8'($urandom()), 16'($urandom())), 1'b0, none);
      n    = $urandom_range(1, 17);
      tsum = 0;
      for (int unsigned k = 0; k < n; k++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(mk_word(lrj_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom()),
                            16'($urandom())),
                    1'b0, none);
        pick = $urandom_range(0, 19);
        if (pick == 0) b = 16'd0;
        else if (pick == 1) b = 16'($urandom_range(1, 65535));
        else b = 16'($urandom_range(1, 6));
        if (b <= 16'd6) tsum += 32'(b);
        send_word(mk_word(lrj_pkg::CMD_ADMIT, 8'($urandom()), b), 1'b0, none);
      end
      ticks = tsum + $urandom_range(0, 3);
      if (ticks > 60) ticks = 60;
      for (int unsigned k = 0; k < ticks; k++) begin
        // late arrival while the table is running
        if ($urandom_range(0, 9) == 0)
          send_word(mk_word(lrj_pkg::CMD_ADMIT, 8'($urandom()), 16'($urandom_range(1, 6))),
                    1'b0, none);
        send_word(mk_word(lrj_pkg::CMD_TICK, 8'($urandom()), 16'($urandom())), 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    no_gaps  = 1'b0;
    while (sched_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/lrj_pkg.sv
src/lrj_table.sv
src/longest_remaining_job_scheduler.sv
test/tb_top.sv
